/* hw/rtl/gaa_pkg.sv */
package gaa_pkg;

	localparam int ValueW = 64;
	localparam int CountW = 48;
	localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

	// Store geometry; the word fields below are sized for it.
	localparam int GroupRows     = 1024;
	localparam int SlotsPerGroup = 8;

	typedef enum logic [1:0] {
		ACT_INIT   = 2'd0,
		ACT_UPDATE = 2'd1,
		ACT_MERGE  = 2'd2,
		ACT_READ   = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		KIND_SUM    = 2'd0,
		KIND_ROWS   = 2'd1,
		KIND_NUMSUM = 2'd2,
		KIND_AVG    = 2'd3
	} kind_t;

	localparam logic [0:0] REG_SLOTS_USED = 1'b0;
	localparam logic [0:0] REG_SLOT_KINDS = 1'b1;

	typedef struct packed {
		action_t            action;
		logic [9:0]         group;
		logic [2:0]         slot;
		logic signed [63:0] value;
		logic [47:0]        partial_count;
	} in_word_t;

	typedef struct packed {
		logic signed [63:0] result_value;
		logic [47:0]        result_count;
		logic               ignored;
	} out_word_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_CALC,
		ST_DIV,
		ST_OUT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic take_in;
		logic mem_rd;
		logic calc;
		logic div_start;
		logic div_step;
		logic out_load;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic need_div;
		logic div_done;
	} status_t;

endpackage

/* hw/rtl/gaa_ram.sv */
module gaa_ram #(
	parameter int Width = 64,
	parameter int Depth = 8192
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);

	logic [Width-1:0] mem_q [Depth];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* hw/rtl/gaa_datapath.sv */
module gaa_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  gaa_pkg::in_word_t   in_word,
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic [15:0]         cfg_data,
	input  gaa_pkg::cmd_t       cmd,
	output gaa_pkg::status_t    status,
	output gaa_pkg::out_word_t  out_word
);

	localparam int GroupRows     = gaa_pkg::GroupRows;
	localparam int SlotsPerGroup = gaa_pkg::SlotsPerGroup;
	localparam int SlotW   = (SlotsPerGroup > 1) ? $clog2(SlotsPerGroup) : 1;
	localparam int GroupW  = (GroupRows > 1) ? $clog2(GroupRows) : 1;
	localparam int Entries = GroupRows * SlotsPerGroup;
	localparam int AddrW   = $clog2(Entries);

	logic [3:0]  slots_used_q;
	logic [15:0] slot_kinds_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slots_used_q <= 4'd1;
			slot_kinds_q <= 16'd0;
		end else if (cfg_we) begin
			if (cfg_index == gaa_pkg::REG_SLOTS_USED) begin
				slots_used_q <= cfg_data[3:0];
			end else begin
				slots_used_q <= slots_used_q;
				slot_kinds_q <= cfg_data;
			end
		end
	end

	// Slot and group range check on the incoming word.
	logic [4:0] active;
	logic       in_ign;
	always_comb begin
		active = (32'(slots_used_q) > SlotsPerGroup) ? 5'(SlotsPerGroup) : {1'b0, slots_used_q};
		in_ign = ({2'b0, in_word.slot} >= active) || (32'(in_word.group) >= GroupRows);
	end

	gaa_pkg::in_word_t  item_q;
	logic               ign_q;
	gaa_pkg::kind_t     kind_q;
	logic [AddrW-1:0]   addr;

	always_comb begin
		addr = AddrW'(32'(in_word.group[GroupW-1:0]) * SlotsPerGroup
			+ 32'(in_word.slot[SlotW-1:0]));
	end

	always_ff @(posedge clk) begin
		if (cmd.take_in) begin
			item_q <= in_word;
			ign_q  <= in_ign;
			kind_q <= gaa_pkg::kind_t'(slot_kinds_q[{in_word.slot, 1'b0} +: 2]);
		end
	end

	logic [AddrW-1:0] addr_q;
	always_ff @(posedge clk) begin
		if (cmd.take_in) begin
			addr_q <= addr;
		end
	end

	// Sum and count stores.
	logic [63:0] sum_rd;
	logic [47:0] cnt_rd;
	logic [63:0] sum_new;
	logic [47:0] cnt_new;
	logic        wr_en;

	gaa_ram #(.Width(64), .Depth(Entries)) u_sum (
		.clk(clk), .we(wr_en), .waddr(addr_q), .wdata(sum_new),
		.re(cmd.mem_rd), .raddr(addr), .rdata(sum_rd)
	);
	gaa_ram #(.Width(48), .Depth(Entries)) u_cnt (
		.clk(clk), .we(wr_en), .waddr(addr_q), .wdata(cnt_new),
		.re(cmd.mem_rd), .raddr(addr), .rdata(cnt_rd)
	);

	// Read-modify-write update of the entry.
	logic [48:0] cnt_add;
	logic        is_avg;
	always_comb begin
		is_avg  = (kind_q == gaa_pkg::KIND_AVG);
		sum_new = sum_rd;
		cnt_new = cnt_rd;
		cnt_add = 49'(cnt_rd);
		unique case (item_q.action)
			gaa_pkg::ACT_INIT: begin
				sum_new = item_q.value;
				cnt_new = is_avg ? 48'd1 : 48'd0;
			end
			gaa_pkg::ACT_UPDATE: begin
				sum_new = (kind_q == gaa_pkg::KIND_ROWS) ? sum_rd + 64'd1 : sum_rd + item_q.value;
				cnt_add = {1'b0, cnt_rd} + 49'd1;
				if (is_avg) begin
					cnt_new = cnt_add[48] ? gaa_pkg::CountMax : cnt_add[47:0];
				end
			end
			gaa_pkg::ACT_MERGE: begin
				sum_new = sum_rd + item_q.value;
				cnt_add = {1'b0, cnt_rd} + {1'b0, item_q.partial_count};
				if (is_avg) begin
					cnt_new = cnt_add[48] ? gaa_pkg::CountMax : cnt_add[47:0];
				end
			end
			default: begin
			end
		endcase
		wr_en = cmd.calc && !ign_q && (item_q.action != gaa_pkg::ACT_READ);
	end

	logic [63:0] res_sum_q;
	logic [47:0] res_cnt_q;
	always_ff @(posedge clk) begin
		if (cmd.calc) begin
			res_sum_q <= sum_new;
			res_cnt_q <= is_avg ? cnt_new : 48'd0;
		end
	end

	// Restoring divider: one quotient bit a cycle.
	logic [63:0] quo_q;
	logic [63:0] rem_q;
	logic [47:0] div_q;
	logic [6:0]  step_q;
	logic        neg_q;
	logic [64:0] trial;
	logic [63:0] rem_sh;
	always_comb begin
		rem_sh = {rem_q[62:0], quo_q[63]};
		trial  = {1'b0, rem_sh} - {17'd0, div_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= 7'd0;
		end else if (cmd.div_start) begin
			step_q <= 7'd64;
		end else if (cmd.div_step && step_q != 7'd0) begin
			step_q <= step_q - 7'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			neg_q <= res_sum_q[63];
			quo_q <= res_sum_q[63] ? 64'd0 - res_sum_q : res_sum_q;
			rem_q <= 64'd0;
			div_q <= res_cnt_q;
		end else if (cmd.div_step && step_q != 7'd0) begin
			if (!trial[64]) begin
				rem_q <= trial[63:0];
				quo_q <= {quo_q[62:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[62:0], 1'b0};
			end
		end
	end

	always_comb begin
		status.need_div   = !ign_q && item_q.action == gaa_pkg::ACT_READ && is_avg;
		status.div_done   = (step_q == 7'd0);
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			if (ign_q) begin
				out_word <= '{result_value: 64'd0, result_count: 48'd0, ignored: 1'b1};
			end else if (status.need_div) begin
				out_word.result_value <= (div_q == 48'd0) ? 64'd0
					: (neg_q ? 64'd0 - quo_q : quo_q);
				out_word.result_count <= res_cnt_q;
				out_word.ignored      <= 1'b0;
			end else begin
				out_word <= '{result_value: res_sum_q, result_count: res_cnt_q, ignored: 1'b0};
			end
		end
	end

endmodule

/* hw/rtl/gaa_ctrl.sv */
module gaa_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	input  gaa_pkg::status_t  status,
	output gaa_pkg::cmd_t     cmd
);

	gaa_pkg::state_t state_q, state_d;
	logic            out_valid_q, out_valid_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= gaa_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= out_valid_d;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		in_stall    = 1'b1;
		out_valid_d = out_valid_q && out_stall;
		unique case (state_q)
			gaa_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.take_in = 1'b1;
					cmd.mem_rd  = 1'b1;
					state_d     = gaa_pkg::ST_CALC;
				end
			end
			gaa_pkg::ST_CALC: begin
				cmd.calc = 1'b1;
				state_d  = status.need_div ? gaa_pkg::ST_READ : gaa_pkg::ST_OUT;
			end
			gaa_pkg::ST_READ: begin
				cmd.div_start = 1'b1;
				state_d       = gaa_pkg::ST_DIV;
			end
			gaa_pkg::ST_DIV: begin
				cmd.div_step = 1'b1;
				if (status.div_done) begin
					state_d = gaa_pkg::ST_OUT;
				end
			end
			gaa_pkg::ST_OUT: begin
				if (!out_valid_q || !out_stall) begin
					cmd.out_load = 1'b1;
					out_valid_d  = 1'b1;
					state_d      = gaa_pkg::ST_IDLE;
				end
			end
			default: state_d = gaa_pkg::ST_IDLE;
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

/* hw/rtl/group_aggregate_accumulator.sv */
// An accepted init, update, merge or plain read goes from idle via calc to output.
// A read of an average slot also passes through the one-bit-a-cycle divider.
// The block takes a new word only in idle, once the last one is through output.
// The output register lets the next word in while a result waits to be taken.
// Reset clears control state and the configuration; the stores are not cleared.
module group_aggregate_accumulator (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  gaa_pkg::in_word_t   in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output gaa_pkg::out_word_t  out_data,
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic [15:0]         cfg_data
);

	gaa_pkg::cmd_t    cmd;
	gaa_pkg::status_t status;

	gaa_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.out_valid(out_valid), .out_stall(out_stall), .status(status), .cmd(cmd)
	);

	gaa_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .in_word(in_data), .cfg_we(cfg_we),
		.cfg_index(cfg_index), .cfg_data(cfg_data), .cmd(cmd), .status(status),
		.out_word(out_data)
	);

endmodule

/* hw/rtl/gaa_checker.sv */
module gaa_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input gaa_pkg::out_word_t out_data
);

	// A stalled result holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result changed under stall");

	// An accepted word blocks the input in the next cycle.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken twice in a row");

	// An ignored result carries zero fields.
	a_ignored_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.ignored |->
		out_data.result_value == 64'd0 && out_data.result_count == 48'd0)
		else $error("ignored result not zero");

	// An accept made while no result is pending does not bring out a result at once.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && !out_valid |=> !out_valid)
		else $error("result too early");

endmodule

bind group_aggregate_accumulator gaa_checker u_gaa_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);

/* verif/tb_group_aggregate_accumulator.sv */
`timescale 1ns / 100ps

module tb_group_aggregate_accumulator;

	localparam int Groups = 1024;
	localparam int Slots = 8;
	localparam int CycleLimit = 400000;

	typedef struct {
		bit                 is_cfg;
		logic               cfg_idx;
		logic [15:0]        cfg_val;
		gaa_pkg::in_word_t  word;
		bit                 typed;
		gaa_pkg::out_word_t want;
	} plan_row_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	gaa_pkg::in_word_t  in_data;
	logic               out_valid;
	logic               out_stall;
	gaa_pkg::out_word_t out_data;
	logic               cfg_we;
	logic               cfg_index;
	logic [15:0]        cfg_data;

	// Shadow copy of the aggregate store and of the configuration.
	logic [63:0] sum_shadow [Groups*Slots];
	logic [47:0] count_shadow [Groups*Slots];
	bit          written [Groups*Slots];
	logic [3:0]  slots_used_shadow;
	logic [15:0] kinds_shadow;

	gaa_pkg::out_word_t pending_results[$];
	plan_row_t plan[$];
	int        mismatches;
	int        cycles;
	bit        idle_bursts;
	bit        hold_request;

	group_aggregate_accumulator uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int active_slots();
		return (slots_used_shadow > Slots) ? Slots : int'(slots_used_shadow);
	endfunction

	// Applies one word to the shadow store and returns the result it yields.
	function automatic gaa_pkg::out_word_t aggregate_apply(gaa_pkg::in_word_t w);
		gaa_pkg::out_word_t r;
		gaa_pkg::kind_t     kind;
		int                 idx;
		logic [63:0]        mag;
		logic [63:0]        quot;
		logic [48:0]        csum;
		r = '0;
		if (int'(w.slot) >= active_slots()) begin
			r.ignored = 1'b1;
			return r;
		end
		kind = gaa_pkg::kind_t'(kinds_shadow[2*w.slot +: 2]);
		idx = int'(w.group) * Slots + int'(w.slot);
		case (w.action)
			gaa_pkg::ACT_INIT: begin
				sum_shadow[idx] = w.value;
				count_shadow[idx] = (kind == gaa_pkg::KIND_AVG) ? 48'd1 : 48'd0;
				written[idx] = 1'b1;
			end
			gaa_pkg::ACT_UPDATE: begin
				sum_shadow[idx] += (kind == gaa_pkg::KIND_ROWS) ? 64'd1 : w.value;
				if (kind == gaa_pkg::KIND_AVG) begin
					csum = count_shadow[idx] + 49'd1;
					count_shadow[idx] = csum[48] ? gaa_pkg::CountMax : csum[47:0];
				end
			end
			gaa_pkg::ACT_MERGE: begin
				sum_shadow[idx] += w.value;
				if (kind == gaa_pkg::KIND_AVG) begin
					csum = count_shadow[idx] + w.partial_count;
					count_shadow[idx] = csum[48] ? gaa_pkg::CountMax : csum[47:0];
				end
			end
			default: ;
		endcase
		r.result_value = sum_shadow[idx];
		r.result_count = (kind == gaa_pkg::KIND_AVG) ? count_shadow[idx] : 48'd0;
		if (w.action == gaa_pkg::ACT_READ && kind == gaa_pkg::KIND_AVG) begin
			if (r.result_count == 0) begin
				r.result_value = '0;
			end else begin
				mag = sum_shadow[idx][63] ? -sum_shadow[idx] : sum_shadow[idx];
				quot = mag / {16'd0, r.result_count};
				r.result_value = sum_shadow[idx][63] ? -quot : quot;
			end
		end
		return r;
	endfunction

	function automatic void plan_cfg(logic idx, logic [15:0] val);
		plan_row_t p;
		p = '{default: '0};
		p.is_cfg = 1'b1;
		p.cfg_idx = idx;
		p.cfg_val = val;
		plan.push_back(p);
	endfunction

	function automatic void plan_word(gaa_pkg::action_t a, int g, int s, logic [63:0] v,
			logic [47:0] pc, bit typed = 0, logic [63:0] ev = 0,
			logic [47:0] ec = 0, bit ig = 0);
		plan_row_t p;
		p = '{default: '0};
		p.word.action = a;
		p.word.group = 10'(g);
		p.word.slot = 3'(s);
		p.word.value = v;
		p.word.partial_count = pc;
		p.typed = typed;
		p.want.result_value = ev;
		p.want.result_count = ec;
		p.want.ignored = ig;
		plan.push_back(p);
	endfunction

	// Random word; a word for an active entry that was never initialized becomes an init.
	function automatic gaa_pkg::in_word_t random_word();
		gaa_pkg::in_word_t w;
		int                pick;
		w.action = gaa_pkg::action_t'($urandom_range(0, 3));
		w.group = ($urandom_range(0, 3) != 0) ? 10'($urandom_range(0, 15))
			: 10'($urandom_range(0, 1023));
		w.slot = 3'($urandom_range(0, 7));
		pick = $urandom_range(0, 5);
		case (pick)
			0: w.value = {$urandom, $urandom};
			1: w.value = {{56{1'b0}}, 8'($urandom)};
			2: w.value = -64'($urandom_range(1, 200));
			3: w.value = {1'b0, {63{1'b1}}};
			4: w.value = {1'b1, {63{1'b0}}};
			default: w.value = 64'($signed(16'($urandom)));
		endcase
		pick = $urandom_range(0, 7);
		if (pick == 0)
			w.partial_count = 48'({$urandom, $urandom});
		else if (pick == 1)
			w.partial_count = gaa_pkg::CountMax - 48'($urandom_range(0, 3));
		else
			w.partial_count = 48'($urandom_range(0, 20));
		if (int'(w.slot) < active_slots() && !written[int'(w.group) * Slots + int'(w.slot)])
			w.action = gaa_pkg::ACT_INIT;
		return w;
	endfunction

	// Register writes wait until the block has drained.
	task automatic write_reg(logic idx, logic [15:0] val);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (80) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == gaa_pkg::REG_SLOTS_USED)
			slots_used_shadow = val[3:0];
		else
			kinds_shadow = val;
	endtask

	// Offers one word and records its expected result once it is taken.
	task automatic send_word(gaa_pkg::in_word_t w, bit typed, gaa_pkg::out_word_t want);
		gaa_pkg::out_word_t predicted;
		if (idle_bursts && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= w;
		do
			@(posedge clk);
		while (in_stall);
		predicted = aggregate_apply(w);
		pending_results.push_back(typed ? want : predicted);
	endtask

	// Receiver side: random stall bursts plus one long hold-off.
	initial begin
		int hold_left;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				out_stall <= 1'b1;
				hold_left = 400;
				while (hold_left > 0) begin
					@(posedge clk);
					hold_left--;
				end
				out_stall <= 1'b0;
				hold_request = 1'b0;
			end else if (idle_bursts && $urandom_range(0, 3) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 11)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// Result checker.
	always @(posedge clk) begin
		gaa_pkg::out_word_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected word: value %h count %h ignored %b",
						out_data.result_value, out_data.result_count, out_data.ignored);
			end else begin
				want = pending_results.pop_front();
				if (out_data !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %h/%h/%b got %h/%h/%b",
							want.result_value, want.result_count, want.ignored,
							out_data.result_value, out_data.result_count,
							out_data.ignored);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("** group_aggregate_accumulator: FAILED **");
			$finish;
		end
	end

	initial begin
		gaa_pkg::out_word_t none;
		int                 phase_used [6];
		int                 phase_count [6];
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_we = 1'b0;
		cfg_index = gaa_pkg::REG_SLOTS_USED;
		cfg_data = '0;
		mismatches = 0;
		cycles = 0;
		idle_bursts = 1'b1;
		hold_request = 1'b0;
		none = '0;
		slots_used_shadow = 4'd1;
		kinds_shadow = 16'd0;
		foreach (written[i])
			written[i] = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: one active slot, plain sums.
		plan_word(gaa_pkg::ACT_INIT, 0, 0, 64'h7FFF_FFFF_FFFF_FFFF, 0, 1,
			64'h7FFF_FFFF_FFFF_FFFF, 0, 0);
		plan_word(gaa_pkg::ACT_UPDATE, 0, 0, 64'd1, 0, 1, 64'h8000_0000_0000_0000, 0, 0);
		plan_word(gaa_pkg::ACT_MERGE, 0, 0, '1, gaa_pkg::CountMax, 1,
			64'h7FFF_FFFF_FFFF_FFFF, 0, 0);
		plan_word(gaa_pkg::ACT_READ, 0, 0, 0, 0, 1, 64'h7FFF_FFFF_FFFF_FFFF, 0, 0);
		plan_word(gaa_pkg::ACT_INIT, 1023, 0, 64'h8000_0000_0000_0000, 0, 1,
			64'h8000_0000_0000_0000, 0, 0);
		plan_word(gaa_pkg::ACT_INIT, 0, 1, 64'd5, 0, 1, 0, 0, 1);
		plan_word(gaa_pkg::ACT_READ, 5, 7, 0, 0, 1, 0, 0, 1);
		// Every kind: slots 0..3 sum, rows, numeric sum, average; rest average.
		plan_cfg(gaa_pkg::REG_SLOTS_USED, 16'd8);
		plan_cfg(gaa_pkg::REG_SLOT_KINDS, 16'hFFE4);
		plan_word(gaa_pkg::ACT_INIT, 2, 1, 64'd5, 0);
		plan_word(gaa_pkg::ACT_UPDATE, 2, 1, 64'd100, 0, 1, 64'd6, 0, 0);
		plan_word(gaa_pkg::ACT_INIT, 2, 2, 64'd10, 0);
		plan_word(gaa_pkg::ACT_MERGE, 2, 2, -64'd3, 48'd9);
		plan_word(gaa_pkg::ACT_INIT, 2, 3, -64'd7, 0, 1, -64'd7, 48'd1, 0);
		plan_word(gaa_pkg::ACT_UPDATE, 2, 3, 64'd0, 0, 1, -64'd7, 48'd2, 0);
		plan_word(gaa_pkg::ACT_READ, 2, 3, 0, 0, 1, -64'd3, 48'd2, 0);
		plan_word(gaa_pkg::ACT_MERGE, 2, 3, 64'd0, gaa_pkg::CountMax);
		plan_word(gaa_pkg::ACT_UPDATE, 2, 3, 64'd1, 0, 1, -64'd6, gaa_pkg::CountMax, 0);
		plan_word(gaa_pkg::ACT_READ, 2, 3, 0, 0);
		plan_word(gaa_pkg::ACT_INIT, 3, 0, 64'd9, 0);
		// A sum entry read as an average has a zero count.
		plan_cfg(gaa_pkg::REG_SLOT_KINDS, 16'hFFFF);
		plan_word(gaa_pkg::ACT_READ, 3, 0, 0, 0, 1, 0, 0, 0);
		plan_cfg(gaa_pkg::REG_SLOTS_USED, 16'd0);
		plan_word(gaa_pkg::ACT_READ, 2, 1, 0, 0, 1, 0, 0, 1);
		plan_word(gaa_pkg::ACT_UPDATE, 1023, 0, 64'd1, 0, 1, 0, 0, 1);

		foreach (plan[i]) begin
			if (plan[i].is_cfg) begin
				in_valid <= 1'b0;
				write_reg(plan[i].cfg_idx, plan[i].cfg_val);
			end else begin
				send_word(plan[i].word, plan[i].typed, plan[i].want);
			end
		end

		// Random phases through several register settings.
		phase_used = '{8, 15, 3, 0, 1, 8};
		phase_count = '{200, 160, 140, 40, 80, 180};
		for (int p = 0; p < 6; p++) begin
			in_valid <= 1'b0;
			write_reg(gaa_pkg::REG_SLOTS_USED, 16'(phase_used[p]));
			write_reg(gaa_pkg::REG_SLOT_KINDS, (p == 4) ? 16'hFFFF : 16'($urandom));
			if (p == 1)
				hold_request = 1'b1;
			if (p == 5)
				idle_bursts = 1'b0;
			for (int n = 0; n < phase_count[p]; n++)
				send_word(random_word(), 1'b0, none);
		end
		in_valid <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		if (mismatches == 0)
			$display("** group_aggregate_accumulator: PASSED **");
		else
			$display("** group_aggregate_accumulator: FAILED **");
		$finish;
	end

endmodule

/* sim.f */
hw/rtl/gaa_pkg.sv
hw/rtl/gaa_ram.sv
hw/rtl/gaa_datapath.sv
hw/rtl/gaa_ctrl.sv
hw/rtl/group_aggregate_accumulator.sv
hw/rtl/gaa_checker.sv
verif/tb_group_aggregate_accumulator.sv
